[sv/wdac_pkg.sv]
`timescale 1ns / 1ps

package wdac_pkg;

    localparam int DATA_W  = 16;
    localparam int SHIFT_W = 4;

    // one complex value, real part in the low half
    typedef struct packed {
        logic signed [DATA_W-1:0] im;
        logic signed [DATA_W-1:0] re;
    } cplx_t;

    // one ring slot: the sample and the term it produced
    typedef struct packed {
        cplx_t term;
        cplx_t samp;
    } ring_entry_t;

endpackage

[sv/wdac_term.sv]
`timescale 1ns / 1ps

module wdac_term (
    input  wdac_pkg::cplx_t              x,
    input  wdac_pkg::cplx_t              z,
    input  logic [wdac_pkg::SHIFT_W-1:0] shift,
    output wdac_pkg::cplx_t              term
);

    logic signed [31:0] p_rr;
    logic signed [31:0] p_ii;
    logic signed [31:0] p_ri;
    logic signed [31:0] p_ir;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;

    function automatic logic [31:0] sat32(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // magnitude, upper half, shift, then sign restored (truncates toward zero)
    function automatic logic [15:0] make_term(input logic [31:0] p,
                                             input logic [wdac_pkg::SHIFT_W-1:0] sh);
        logic [31:0] mag;
        logic [15:0] hi;
        if (p[31]) begin
            mag = (p == 32'h8000_0000) ? 32'h7FFF_FFFF : (~p + 32'd1);
        end else begin
            mag = p;
        end
        hi = mag[31:16] >> sh;
        return p[31] ? (16'd0 - hi) : hi;
    endfunction

    // conj(x) * z
    assign p_rr = x.re * z.re;
    assign p_ii = x.im * z.im;
    assign p_ri = x.re * z.im;
    assign p_ir = x.im * z.re;

    assign sum_re = {p_rr[31], p_rr} + {p_ii[31], p_ii};
    assign sum_im = {p_ri[31], p_ri} - {p_ir[31], p_ir};

    assign term.re = make_term(sat32(sum_re), shift);
    assign term.im = make_term(sat32(sum_im), shift);

endmodule

[sv/wdac_ring.sv]
`timescale 1ns / 1ps

module wdac_ring #(
    parameter int WINDOW = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic                   wr_en,
    input  wdac_pkg::ring_entry_t  wr_entry,
    output wdac_pkg::ring_entry_t  rd_entry
);

    localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(WINDOW - 1);
    localparam logic [ADDR_W-1:0] ONE  = ADDR_W'(1);

    wdac_pkg::ring_entry_t mem [WINDOW];

    logic [ADDR_W-1:0]     rd_pos_reg;
    logic [ADDR_W-1:0]     rd_pos_next;
    logic [ADDR_W-1:0]     wr_pos_reg;
    logic [ADDR_W-1:0]     wr_pos_next;
    logic                  filled_reg;
    logic                  filled_next;
    logic                  rd_filled_reg;
    wdac_pkg::ring_entry_t rd_data_reg;

    assign rd_pos_next = (rd_pos_reg == LAST) ? '0 : rd_pos_reg + ONE;
    assign wr_pos_next = (wr_pos_reg == LAST) ? '0 : wr_pos_reg + ONE;
    // once the read side has wrapped, every slot it reaches has been written
    assign filled_next = filled_reg | (rd_en & (rd_pos_reg == LAST));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pos_reg    <= '0;
            wr_pos_reg    <= '0;
            filled_reg    <= 1'b0;
            rd_filled_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_pos_reg    <= rd_pos_next;
                filled_reg    <= filled_next;
                rd_filled_reg <= filled_reg;
            end
            if (wr_en) begin
                wr_pos_reg <= wr_pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_pos_reg] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_pos_reg];
        end
    end

    // unwritten slots read as zero
    assign rd_entry = rd_filled_reg ? rd_data_reg : '0;

`ifndef ASSERT_OFF
    a_wr_outstanding: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (rd_pos_reg != wr_pos_reg))
        else $error("ring write with no item outstanding");

    a_filled_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg |=> filled_reg)
        else $error("ring fill flag dropped");
`endif

endmodule

[sv/windowed_delayed_autocorrelator_unit.sv]
`timescale 1ns / 1ps
// Sliding-window delayed autocorrelator.
// Slave stream s_*: one complex sample per item, tdata = {imag, real}.
// Master stream m_*: one correlation sum per item, tdata = {imag, real}.
// Each item multiplies conj(sample) by the sample WINDOW items earlier,
// reduces it to a 16-bit term scaled by accumulation_shift and updates a
// running window sum with 16-bit wrap.
// Throughput: one item per clock while m_tready keeps up; the ring memory
// has one write and one read port, which is all the window needs per item.
// A sample's sum reaches m_tdata through two register stages: input/ring
// read, then result.
// The user writes the shift register (cfg_wr_en/cfg_wr_data) only while idle;
// the block does not enforce this. Reset (aresetn low, synchronous) clears the
// ring pointers, the fill flag, the running sum, the shift and both valid
// flags; the ring reads as zero until WINDOW items have passed.
// When the receiver stalls, the result holds, one more item sits in the
// input stage and s_tready then drops until the result is taken.
module windowed_delayed_autocorrelator_unit #(
    parameter int WINDOW = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // accumulation_shift
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [15:0] sample_real, [31:16] sample_imag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // [15:0] corr_real, [31:16] corr_imag
);

    logic [wdac_pkg::SHIFT_W-1:0] shift_reg;

    logic                  s1_valid_reg;
    wdac_pkg::cplx_t       s1_x_reg;
    logic                  out_valid_reg;
    wdac_pkg::cplx_t       out_reg;
    wdac_pkg::cplx_t       sum_reg;
    wdac_pkg::cplx_t       sum_next;

    logic                  accept;
    logic                  s1_adv;
    wdac_pkg::ring_entry_t old_entry;
    wdac_pkg::ring_entry_t new_entry;
    wdac_pkg::cplx_t       new_term;

    assign s1_adv   = s1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~s1_valid_reg | s1_adv;
    assign accept   = s_tvalid & s_tready;

    wdac_ring #(
        .WINDOW(WINDOW)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .wr_en    (s1_adv),
        .wr_entry (new_entry),
        .rd_entry (old_entry)
    );

    wdac_term u_term (
        .x     (s1_x_reg),
        .z     (old_entry.samp),
        .shift (shift_reg),
        .term  (new_term)
    );

    assign new_entry.samp = s1_x_reg;
    assign new_entry.term = new_term;

    assign sum_next.re = sum_reg.re - old_entry.term.re + new_term.re;
    assign sum_next.im = sum_reg.im - old_entry.term.im + new_term.im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                shift_reg <= cfg_wr_data;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
                sum_reg       <= sum_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_x_reg <= s_tdata;
        end
        if (s1_adv) begin
            out_reg <= sum_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

`ifndef ASSERT_OFF
    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("item accepted while both stages are blocked");

    a_adv_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> out_valid_reg)
        else $error("advanced item produced no result");

    a_sum_matches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg == sum_reg))
        else $error("presented result differs from running sum");
`endif

endmodule
